FILE: rtl/core/rmth_pkg.sv
// Package for the two-heap running median core: constants, types, state codes.
// No dependencies.
`default_nettype none
package rmth_pkg;
  localparam int unsigned HalfCapacity = 512;
  localparam int unsigned SampleWidth  = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TOP_RD,
    ST_TOP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

FILE: rtl/core/rmth_heap_mem.sv
// One heap store: synchronous single-port write, two registered read ports.
// Depends on rmth_pkg for default parameters.
`default_nettype none
module rmth_heap_mem #(
  parameter int unsigned Depth = rmth_pkg::HalfCapacity,
  parameter int unsigned Width = rmth_pkg::SampleWidth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] wa_i,
  input  logic [Width-1:0]         wd_i,
  input  logic [$clog2(Depth)-1:0] ra0_i,
  input  logic [$clog2(Depth)-1:0] ra1_i,
  output logic [Width-1:0]         rd0_o,
  output logic [Width-1:0]         rd1_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[wa_i] <= wd_i;
    rd0_o <= mem[ra0_i];
    rd1_o <= mem[ra1_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/running_median_two_heaps_core.sv
// Two-heap running median core, one transaction in flight at a time.
// A dropped sample goes straight to the result. A stored one sifts up from its new slot,
// then both tops are read; if they cross, the tops swap and the old upper top sifts down
// the lower heap, then the old lower top sifts down the upper heap.
// Input ready only when idle, from the cycle after the result is taken.
// Reset: fill counts and control clear asynchronously; heap memories are not cleared.
`default_nettype none
module running_median_two_heaps_core #(
  parameter int unsigned HalfCapacity = rmth_pkg::HalfCapacity,
  parameter int unsigned SampleWidth  = rmth_pkg::SampleWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic signed [SampleWidth:0]   median_doubled_o,
  output logic                          accepted_o,
  output logic [$clog2(2*HalfCapacity):0] stored_count_o
);
  localparam int unsigned AW = $clog2(HalfCapacity);
  localparam int unsigned CW = $clog2(HalfCapacity) + 1;
  localparam int unsigned TW = $clog2(2*HalfCapacity) + 1;
  localparam int unsigned SW = SampleWidth;

  rmth_pkg::state_e state_q, state_d;

  // Fill levels and working registers.
  logic [CW-1:0] lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  logic [AW:0]   pos_q, pos_d;      // one extra bit: child index may reach 2*pos+2
  logic          heap_q, heap_d;    // 0 = lower (max), 1 = upper (min)
  logic          both_q, both_d;    // sift down the upper heap after the lower one
  logic          acc_q, acc_d;
  logic signed [SW-1:0] val_q, val_d;   // value being moved
  logic signed [SW-1:0] ltop_q, ltop_d, utop_q, utop_d;
  logic signed [SW:0]   med_q, med_d;

  // Memory ports.
  logic          lwe, uwe;
  logic [AW-1:0] wa, ra0, ra1;
  logic signed [SW-1:0] wd, lrd0, lrd1, urd0, urd1;

  rmth_heap_mem #(.Depth(HalfCapacity), .Width(SW)) u_lower (
    .clk_i, .we_i(lwe), .wa_i(wa), .wd_i(wd), .ra0_i(ra0), .ra1_i(ra1),
    .rd0_o(lrd0), .rd1_o(lrd1));
  rmth_heap_mem #(.Depth(HalfCapacity), .Width(SW)) u_upper (
    .clk_i, .we_i(uwe), .wa_i(wa), .wd_i(wd), .ra0_i(ra0), .ra1_i(ra1),
    .rd0_o(urd0), .rd1_o(urd1));

  logic signed [SW-1:0] rd0, rd1;
  assign rd0 = heap_q ? urd0 : lrd0;
  assign rd1 = heap_q ? urd1 : lrd1;

  // Ranking: a above b in the active heap.
  function automatic logic above(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
                                 input logic upper);
    above = upper ? (a < b) : (a > b);
  endfunction

  logic [CW-1:0] n_act;
  logic [AW:0]   parent, lchild, rchild;
  logic          l_ok, r_ok, pick_r, go_l;
  logic signed [SW-1:0] best;
  assign n_act  = heap_q ? ucnt_q : lcnt_q;
  assign parent = (pos_q - (AW+1)'(1)) >> 1;
  assign lchild = {pos_q[AW-1:0], 1'b1};
  assign rchild = lchild + (AW+1)'(1);
  assign l_ok   = CW'(lchild) < n_act && lchild <= (AW+1)'(HalfCapacity - 1);
  assign r_ok   = CW'(rchild) < n_act && rchild <= (AW+1)'(HalfCapacity - 1);
  assign pick_r = r_ok && above(rd1, rd0, heap_q);
  assign best   = pick_r ? rd1 : rd0;
  assign go_l   = l_ok && above(best, val_q, heap_q);

  // Tops cross: lower top above upper top while both heaps hold samples.
  logic swap_tops;
  assign swap_tops = ucnt_q != '0 && lrd0 > urd0;

  logic hs_in, hs_out;
  assign hs_in  = sample_valid_i && sample_ready_o;
  assign hs_out = result_valid_o && result_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmth_pkg::ST_IDLE: begin
        if (hs_in) begin
          if ((lcnt_q > ucnt_q && ucnt_q < CW'(HalfCapacity)) ||
              (lcnt_q <= ucnt_q && lcnt_q < CW'(HalfCapacity))) begin
            state_d = rmth_pkg::ST_UP_RD;
          end else begin
            state_d = rmth_pkg::ST_OUT;
          end
        end
      end
      rmth_pkg::ST_UP_RD: begin
        if (pos_q == '0) state_d = rmth_pkg::ST_TOP_RD;
        else state_d = rmth_pkg::ST_UP_CMP;
      end
      rmth_pkg::ST_UP_CMP: begin
        if (above(val_q, rd0, heap_q)) state_d = rmth_pkg::ST_UP_RD;
        else state_d = rmth_pkg::ST_TOP_RD;
      end
      rmth_pkg::ST_TOP_RD:  state_d = rmth_pkg::ST_TOP_CMP;
      rmth_pkg::ST_TOP_CMP: begin
        if (swap_tops) state_d = rmth_pkg::ST_DN_RD;
        else state_d = rmth_pkg::ST_OUT;
      end
      rmth_pkg::ST_DN_RD:   state_d = rmth_pkg::ST_DN_CMP;
      rmth_pkg::ST_DN_CMP: begin
        if (go_l) state_d = rmth_pkg::ST_DN_RD;
        else if (both_q) state_d = rmth_pkg::ST_DN_RD;
        else state_d = rmth_pkg::ST_OUT;
      end
      rmth_pkg::ST_OUT: begin
        if (hs_out) state_d = rmth_pkg::ST_IDLE;
      end
      default: state_d = rmth_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    lcnt_d = lcnt_q; ucnt_d = ucnt_q; pos_d = pos_q; heap_d = heap_q;
    both_d = both_q; acc_d = acc_q; val_d = val_q;
    ltop_d = ltop_q; utop_d = utop_q; med_d = med_q;
    lwe = 1'b0; uwe = 1'b0; wa = pos_q[AW-1:0]; wd = val_q;
    ra0 = '0; ra1 = '0;
    case (state_q)
      rmth_pkg::ST_IDLE: begin
        if (hs_in) begin
          val_d  = sample_i;
          heap_d = lcnt_q > ucnt_q;
          acc_d  = 1'b0;
          if (lcnt_q > ucnt_q) begin
            if (ucnt_q < CW'(HalfCapacity)) begin
              acc_d = 1'b1; pos_d = ucnt_q[AW:0]; ucnt_d = ucnt_q + CW'(1);
            end
          end else if (lcnt_q < CW'(HalfCapacity)) begin
            acc_d = 1'b1; pos_d = lcnt_q[AW:0]; lcnt_d = lcnt_q + CW'(1);
          end
        end
      end
      rmth_pkg::ST_UP_RD: begin
        // Fetch the parent; at the root just place the value.
        ra0 = parent[AW-1:0];
        if (pos_q == '0) begin
          lwe = !heap_q; uwe = heap_q;
        end
      end
      rmth_pkg::ST_UP_CMP: begin
        lwe = !heap_q; uwe = heap_q;
        if (above(val_q, rd0, heap_q)) begin
          wd = rd0; pos_d = parent;   // move parent down, climb
        end
      end
      rmth_pkg::ST_TOP_RD: begin
        ra0 = '0;
      end
      rmth_pkg::ST_TOP_CMP: begin
        ltop_d = lrd0; utop_d = urd0;
        if (swap_tops) begin
          // Swap tops: sift old upper top down the lower heap, then the reverse.
          ltop_d = urd0; utop_d = lrd0;
          heap_d = 1'b0; both_d = 1'b1; pos_d = '0; val_d = urd0;
        end
      end
      rmth_pkg::ST_DN_RD: begin
        ra0 = lchild[AW-1:0];
        ra1 = rchild[AW-1:0];
      end
      rmth_pkg::ST_DN_CMP: begin
        lwe = !heap_q; uwe = heap_q;
        if (go_l) begin
          wd = best; pos_d = pick_r ? rchild : lchild;
          if (pos_q == '0) begin
            if (heap_q) utop_d = best; else ltop_d = best;
          end
        end else if (both_q) begin
          both_d = 1'b0; heap_d = 1'b1; pos_d = '0;
          // utop still holds the old lower top, which now sifts down the upper heap
          val_d = utop_q;
        end
      end
      default: ;
    endcase
    if (lcnt_d == ucnt_d)
      med_d = (SW+1)'(ltop_d) + (SW+1)'(utop_d);
    else
      med_d = {ltop_d, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmth_pkg::ST_IDLE;
      lcnt_q <= '0; ucnt_q <= '0; heap_q <= 1'b0; both_q <= 1'b0; acc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q <= lcnt_d; ucnt_q <= ucnt_d; heap_q <= heap_d;
      both_q <= both_d; acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; val_q <= val_d; ltop_q <= ltop_d; utop_q <= utop_d;
    // Median only settles once tops are known; hold it outside TOP_CMP/DN_CMP.
    if (state_q == rmth_pkg::ST_TOP_CMP || state_q == rmth_pkg::ST_DN_CMP) med_q <= med_d;
  end

  assign sample_ready_o   = state_q == rmth_pkg::ST_IDLE;
  assign result_valid_o   = state_q == rmth_pkg::ST_OUT;
  assign median_doubled_o = med_q;
  assign accepted_o       = acc_q;
  assign stored_count_o   = TW'(lcnt_q) + TW'(ucnt_q);

  // Lower heap never trails the upper heap, and leads by at most one.
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcnt_q == ucnt_q) || (lcnt_q == ucnt_q + CW'(1)))
    else $error("heap fill levels out of balance");
  // A dropped transaction leaves the fill levels untouched.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !accepted_o) |-> $stable(stored_count_o))
    else $error("dropped sample changed fill level");
  // The result is held until taken.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_ready_i) |=> result_valid_o)
    else $error("result dropped before handshake");
endmodule
`default_nettype wire
